// File: hw/rtl/q2e_pkg.sv
// Shared types, constants and helper functions for the quaternion to Euler block.
`default_nettype none

package q2e_pkg;

  // Default number of CORDIC micro-rotations
  localparam int CORDIC_STEPS_DEF = 16;

  // Datapath widths
  localparam int MW  = 30;  // multiplier operand
  localparam int PW  = 60;  // multiplier product
  localparam int SW  = 34;  // product sums
  localparam int XW  = 38;  // CORDIC x / y
  localparam int ZW  = 33;  // CORDIC angle accumulator, degrees * 2^22
  localparam int AW  = 17;  // angles in 1/64 degree, working width
  localparam int SHW = 5;   // CORDIC shift amount / table index
  localparam int VW  = 57;  // square root radicand
  localparam int RW  = 29;  // square root result
  localparam int SQ_STEPS = 29;

  localparam logic signed [XW-1:0] ONE_Q28 = XW'(64'sd268435456);
  localparam logic signed [ZW-1:0] ANG180  = ZW'(64'sd754974720);

  localparam logic signed [AW-1:0] FULL_TURN    = AW'(23040);
  localparam logic signed [AW-1:0] HALF_TURN    = AW'(11520);
  localparam logic signed [AW-1:0] QUARTER_TURN = AW'(5760);

  // Command codes
  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_TARE   = 2'd1;
  localparam logic [1:0] CMD_POLL   = 2'd2;
  localparam logic [1:0] CMD_RSVD   = 2'd3;  // unused code, answered as a poll

  // Configuration register indexes
  localparam logic [2:0] REG_NEGATE_X     = 3'd0;
  localparam logic [2:0] REG_NEGATE_Y     = 3'd1;
  localparam logic [2:0] REG_NEGATE_Z     = 3'd2;
  localparam logic [2:0] REG_ROLL_OFFSET  = 3'd3;
  localparam logic [2:0] REG_PITCH_OFFSET = 3'd4;
  localparam logic [2:0] REG_TIMEOUT      = 3'd5;

  // atan(2^-i) in degrees * 2^22
  function automatic logic signed [ZW-1:0] atan_entry(input logic [SHW-1:0] idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      5'd0:  v = ZW'(188743680);
      5'd1:  v = ZW'(111421900);
      5'd2:  v = ZW'(58872272);
      5'd3:  v = ZW'(29884485);
      5'd4:  v = ZW'(15000234);
      5'd5:  v = ZW'(7507429);
      5'd6:  v = ZW'(3754631);
      5'd7:  v = ZW'(1877430);
      5'd8:  v = ZW'(938729);
      5'd9:  v = ZW'(469366);
      5'd10: v = ZW'(234683);
      5'd11: v = ZW'(117342);
      5'd12: v = ZW'(58671);
      5'd13: v = ZW'(29335);
      5'd14: v = ZW'(14668);
      5'd15: v = ZW'(7334);
      5'd16: v = ZW'(3667);
      5'd17: v = ZW'(1833);
      5'd18: v = ZW'(917);
      5'd19: v = ZW'(458);
      5'd20: v = ZW'(229);
      5'd21: v = ZW'(115);
      5'd22: v = ZW'(57);
      5'd23: v = ZW'(29);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [AW-1:0] clamp_ang(input logic signed [AW-1:0] a,
                                                     input logic signed [AW-1:0] lim);
    logic signed [AW-1:0] r;
    if (a > lim) r = lim;
    else if (a < -lim) r = -lim;
    else r = a;
    return r;
  endfunction

  function automatic logic signed [AW-1:0] wrap_half(input logic signed [AW-1:0] a);
    logic signed [AW-1:0] r;
    r = a;
    if (r > HALF_TURN) r = r - FULL_TURN;
    if (r < -HALF_TURN) r = r + FULL_TURN;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/q2e_chan_if.sv
// Request and response channel interfaces of the quaternion to Euler block.
`default_nettype none

interface q2e_req_if;
  logic              valid;
  logic              ready;
  logic        [1:0] cmd;
  logic signed [15:0] quat_real;
  logic signed [15:0] quat_i;
  logic signed [15:0] quat_j;
  logic signed [15:0] quat_k;
  logic        [1:0] sample_accuracy;
  logic       [31:0] now_ms;

  modport source (output valid, cmd, quat_real, quat_i, quat_j, quat_k,
                  sample_accuracy, now_ms, input ready);
  modport sink   (input valid, cmd, quat_real, quat_i, quat_j, quat_k,
                  sample_accuracy, now_ms, output ready);
endinterface

interface q2e_rsp_if;
  logic              valid;
  logic              ready;
  logic signed [14:0] roll;
  logic signed [13:0] pitch;
  logic       [14:0] heading;
  logic signed [14:0] rel_yaw;
  logic        [1:0] accuracy;
  logic              healthy;

  modport source (output valid, roll, pitch, heading, rel_yaw, accuracy, healthy,
                  input ready);
  modport sink   (input valid, roll, pitch, heading, rel_yaw, accuracy, healthy,
                  output ready);
endinterface

`default_nettype wire

// File: hw/rtl/q2e_mul.sv
// Shared signed multiplier with registered product.
`default_nettype none

module q2e_mul (
  input  wire logic                            clk,
  input  wire logic signed [q2e_pkg::MW-1:0]   a,
  input  wire logic signed [q2e_pkg::MW-1:0]   b,
  output logic signed      [q2e_pkg::PW-1:0]   p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

`default_nettype wire

// File: hw/rtl/q2e_isqrt.sv
// Bit-serial integer square root, two radicand bits per cycle.
`default_nettype none

module q2e_isqrt (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [q2e_pkg::VW-1:0]      v,
  output logic                             done,
  output logic      [q2e_pkg::RW-1:0]      root
);

  localparam int VW = q2e_pkg::VW;

  logic [VW-1:0] rem;
  logic [VW:0]   res;
  logic [VW-1:0] bitm;
  logic [4:0]    cnt;
  logic          busy;
  logic [VW:0]   sum;

  assign sum  = res + {1'b0, bitm};
  assign root = res[q2e_pkg::RW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 5'(q2e_pkg::SQ_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= v;
      res  <= '0;
      bitm <= VW'(1) << (VW - 1);
      cnt  <= '0;
    end else if (busy) begin
      // Keep the remainder when the trial subtraction would go negative
      if ({1'b0, rem} >= sum) begin
        rem <= VW'({1'b0, rem} - sum);
        res <= (res >> 1) + {1'b0, bitm};
      end else begin
        res <= res >> 1;
      end
      bitm <= bitm >> 2;
      cnt  <= cnt + 5'd1;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/q2e_cordic.sv
// Iterative vectoring CORDIC: atan2(y, x) in 1/64 degree, one rotation per cycle.
`default_nettype none

module q2e_cordic #(
  parameter int STEPS = q2e_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic signed [q2e_pkg::XW-1:0]     x0,
  input  wire logic signed [q2e_pkg::XW-1:0]     y0,
  output logic                                   done,
  output logic signed      [q2e_pkg::AW-1:0]     angle
);

  localparam int XW = q2e_pkg::XW;
  localparam int ZW = q2e_pkg::ZW;
  localparam int CW = $clog2(STEPS);

  logic signed [XW-1:0] x, y, xs, ys;
  logic signed [ZW-1:0] z, zr, at;
  logic [CW-1:0]        cnt;
  logic [q2e_pkg::SHW-1:0] sh;
  logic                 busy;
  logic                 zero;

  assign sh    = q2e_pkg::SHW'(cnt);
  assign xs    = x >>> sh;
  assign ys    = y >>> sh;
  assign at    = q2e_pkg::atan_entry(sh);
  assign zr    = (z + ZW'(32768)) >>> 16;
  assign angle = zero ? '0 : zr[q2e_pkg::AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      zero <= (x0 == '0) && (y0 == '0);
      cnt  <= '0;
      // Fold the left half plane onto the right one
      if (x0 < 0) begin
        x <= -x0;
        y <= -y0;
        z <= (y0 < 0) ? -q2e_pkg::ANG180 : q2e_pkg::ANG180;
      end else begin
        x <= x0;
        y <= y0;
        z <= '0;
      end
    end else if (busy) begin
      if (y > 0) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end
      cnt <= cnt + CW'(1);
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/quaternion_to_euler_tared.sv
// Top level: tared roll, pitch and heading from Q14 rotation quaternions.
// Sequence: a rotation sample runs the shared multiplier schedule, then the square root,
//   then three atan2 runs (roll, pitch, yaw) on the shared CORDIC unit, then a final step.
//   Tare and poll go straight to the final step.
// Throughput: one command at a time; the next transfer is taken once the sequencer idles,
//   even while the previous response still waits in the output register.
// Reset: rst is synchronous, active high; it resets config, held values, rsp.valid and control.
`default_nettype none

module quaternion_to_euler_tared #(
  parameter int CORDIC_STEPS = q2e_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wr_en,
  input  wire logic [2:0]  wr_index,
  input  wire logic [15:0] wr_data,
  q2e_req_if.sink          req,
  q2e_rsp_if.source        rsp
);

  localparam int MW = q2e_pkg::MW;
  localparam int PW = q2e_pkg::PW;
  localparam int SW = q2e_pkg::SW;
  localparam int TW = SW + 1;
  localparam int XW = q2e_pkg::XW;
  localparam int AW = q2e_pkg::AW;
  localparam int VW = q2e_pkg::VW;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_SQRT  = 3'd2;
  localparam logic [2:0] S_ROLL  = 3'd3;
  localparam logic [2:0] S_PITCH = 3'd4;
  localparam logic [2:0] S_YAW   = 3'd5;
  localparam logic [2:0] S_FINAL = 3'd6;

  // Multiplier schedule: products issued in this order, each lands in the following cycle
  localparam logic [3:0] M_WX = 4'd0;
  localparam logic [3:0] M_YZ = 4'd1;
  localparam logic [3:0] M_XX = 4'd2;
  localparam logic [3:0] M_YY = 4'd3;
  localparam logic [3:0] M_ZZ = 4'd4;
  localparam logic [3:0] M_WY = 4'd5;
  localparam logic [3:0] M_ZX = 4'd6;
  localparam logic [3:0] M_WZ = 4'd7;
  localparam logic [3:0] M_XY = 4'd8;
  localparam logic [3:0] M_SQ = 4'd9;
  localparam logic [3:0] M_END = 4'd10;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic               negate_x, negate_y, negate_z;
  logic signed [14:0] roll_level_offset, pitch_level_offset;
  logic        [15:0] fresh_timeout_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      negate_x           <= 1'b0;
      negate_y           <= 1'b0;
      negate_z           <= 1'b0;
      roll_level_offset  <= '0;
      pitch_level_offset <= '0;
      fresh_timeout_ms   <= 16'd100;
    end else if (wr_en) begin
      unique case (wr_index)
        q2e_pkg::REG_NEGATE_X:     negate_x           <= wr_data[0];
        q2e_pkg::REG_NEGATE_Y:     negate_y           <= wr_data[0];
        q2e_pkg::REG_NEGATE_Z:     negate_z           <= wr_data[0];
        q2e_pkg::REG_ROLL_OFFSET:  roll_level_offset  <= $signed(wr_data[14:0]);
        q2e_pkg::REG_PITCH_OFFSET: pitch_level_offset <= $signed(wr_data[14:0]);
        q2e_pkg::REG_TIMEOUT:      fresh_timeout_ms   <= wr_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Command capture
  // ---------------------------------------------------------------------------
  logic [2:0] state;
  logic [3:0] mcnt;

  logic        [1:0] cmd_q;
  logic signed [15:0] w_q, x_q, y_q, z_q;
  logic        [1:0] acc_q;
  logic       [31:0] now_q;

  logic req_xfer;
  assign req.ready = (state == S_IDLE);
  assign req_xfer  = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (req_xfer) begin
      cmd_q <= req.cmd;
      w_q   <= req.quat_real;
      x_q   <= req.quat_i;
      y_q   <= req.quat_j;
      z_q   <= req.quat_k;
      acc_q <= req.sample_accuracy;
      now_q <= req.now_ms;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier and product sums
  // ---------------------------------------------------------------------------
  logic signed [MW-1:0] ma, mb, t2c;
  logic signed [PW-1:0] mul_p;
  logic signed [SW-1:0] prod;
  // s0 = wx+yz, s1 = xx+yy, s2 = wy-zx, s3 = wz+xy, s4 = yy+zz
  logic signed [SW-1:0] s0, s1, s2, s3, s4;
  logic signed [TW-1:0] t2x;

  q2e_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mul_p));

  assign prod = SW'(mul_p);
  assign t2x  = TW'(s2) <<< 1;

  // Clamp the asin argument to +-1.0
  always_comb begin
    if (t2x > TW'(q2e_pkg::ONE_Q28)) t2c = MW'(q2e_pkg::ONE_Q28);
    else if (t2x < -TW'(q2e_pkg::ONE_Q28)) t2c = -MW'(q2e_pkg::ONE_Q28);
    else t2c = MW'(t2x);
  end

  always_comb begin
    ma = MW'(w_q);
    mb = MW'(x_q);
    unique case (mcnt)
      M_WX: begin ma = MW'(w_q); mb = MW'(x_q); end
      M_YZ: begin ma = MW'(y_q); mb = MW'(z_q); end
      M_XX: begin ma = MW'(x_q); mb = MW'(x_q); end
      M_YY: begin ma = MW'(y_q); mb = MW'(y_q); end
      M_ZZ: begin ma = MW'(z_q); mb = MW'(z_q); end
      M_WY: begin ma = MW'(w_q); mb = MW'(y_q); end
      M_ZX: begin ma = MW'(z_q); mb = MW'(x_q); end
      M_WZ: begin ma = MW'(w_q); mb = MW'(z_q); end
      M_XY: begin ma = MW'(x_q); mb = MW'(y_q); end
      M_SQ: begin ma = t2c;      mb = t2c;      end
      default: ;
    endcase
  end

  // Fold each product into its sum the cycle after it was issued
  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      unique case (mcnt)
        M_WX + 4'd1: s0 <= prod;
        M_YZ + 4'd1: s0 <= s0 + prod;
        M_XX + 4'd1: s1 <= prod;
        M_YY + 4'd1: begin s1 <= s1 + prod; s4 <= prod; end
        M_ZZ + 4'd1: s4 <= s4 + prod;
        M_WY + 4'd1: s2 <= prod;
        M_ZX + 4'd1: s2 <= s2 - prod;
        M_WZ + 4'd1: s3 <= prod;
        M_XY + 4'd1: s3 <= s3 + prod;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Square root for the asin cosine leg: floor(sqrt(2^56 - t2^2))
  // ---------------------------------------------------------------------------
  logic                    sq_start, sq_done;
  logic [VW-1:0]           sq_v;
  logic [q2e_pkg::RW-1:0]  sq_root;

  assign sq_start = (state == S_MUL) && (mcnt == M_END);
  assign sq_v     = (VW'(1) << (VW - 1)) - mul_p[VW-1:0];

  q2e_isqrt u_isqrt (
    .clk(clk), .rst(rst), .start(sq_start), .v(sq_v), .done(sq_done), .root(sq_root)
  );

  // ---------------------------------------------------------------------------
  // Shared CORDIC: roll, then pitch, then yaw
  // ---------------------------------------------------------------------------
  logic                 cd_start, cd_done;
  logic signed [XW-1:0] cd_x0, cd_y0;
  logic signed [AW-1:0] cd_angle;

  always_comb begin
    cd_start = 1'b0;
    cd_x0    = q2e_pkg::ONE_Q28 - (XW'(s1) <<< 1);
    cd_y0    = XW'(s0) <<< 1;
    unique case (state)
      S_SQRT: begin
        cd_start = sq_done;
        cd_x0    = q2e_pkg::ONE_Q28 - (XW'(s1) <<< 1);
        cd_y0    = XW'(s0) <<< 1;
      end
      S_ROLL: begin
        cd_start = cd_done;
        cd_x0    = XW'({1'b0, sq_root});
        cd_y0    = XW'(t2c);
      end
      S_PITCH: begin
        cd_start = cd_done;
        cd_x0    = q2e_pkg::ONE_Q28 - (XW'(s4) <<< 1);
        cd_y0    = XW'(s3) <<< 1;
      end
      default: ;
    endcase
  end

  q2e_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(cd_start), .x0(cd_x0), .y0(cd_y0),
    .done(cd_done), .angle(cd_angle)
  );

  // Raw angles after clamp and axis sign
  logic signed [AW-1:0] r_q, p_q, yw_q;
  logic signed [AW-1:0] cl_half, cl_quarter;

  assign cl_half    = q2e_pkg::clamp_ang(cd_angle, q2e_pkg::HALF_TURN);
  assign cl_quarter = q2e_pkg::clamp_ang(cd_angle, q2e_pkg::QUARTER_TURN);

  always_ff @(posedge clk) begin
    if (cd_done) begin
      if (state == S_ROLL)  r_q  <= negate_x ? -cl_half : cl_half;
      if (state == S_PITCH) p_q  <= negate_y ? -cl_quarter : cl_quarter;
      if (state == S_YAW)   yw_q <= negate_z ? -cl_half : cl_half;
    end
  end

  // ---------------------------------------------------------------------------
  // Held orientation, tare and health
  // ---------------------------------------------------------------------------
  logic signed [14:0] tare_offset;
  logic               tare_done;
  logic       [31:0]  last_sample_time;
  logic               sample_seen;
  logic signed [14:0] held_roll;
  logic signed [13:0] held_pitch;
  logic       [14:0]  held_heading;
  logic signed [14:0] held_yaw;
  logic        [1:0]  held_accuracy;

  logic signed [14:0] tare_offset_next, held_roll_next, held_yaw_next;
  logic signed [13:0] held_pitch_next;
  logic       [14:0]  held_heading_next;
  logic        [1:0]  held_accuracy_next;
  logic               tare_done_next;
  logic       [31:0]  last_sample_time_next;
  logic               seen_eff, healthy_now;
  logic       [31:0]  age;
  logic signed [AW-1:0] toff, rr, pp, hd;

  logic fin_go;
  assign fin_go = (state == S_FINAL) && (!rsp.valid || rsp.ready);

  always_comb begin
    tare_offset_next      = tare_offset;
    tare_done_next        = tare_done;
    held_roll_next        = held_roll;
    held_pitch_next       = held_pitch;
    held_heading_next     = held_heading;
    held_yaw_next         = held_yaw;
    held_accuracy_next    = held_accuracy;
    last_sample_time_next = last_sample_time;
    seen_eff              = sample_seen;

    rr   = q2e_pkg::clamp_ang(r_q - AW'(roll_level_offset), q2e_pkg::HALF_TURN);
    pp   = q2e_pkg::clamp_ang(p_q - AW'(pitch_level_offset), q2e_pkg::QUARTER_TURN);
    hd   = (yw_q < 0) ? yw_q + q2e_pkg::FULL_TURN : yw_q;
    // First sample tares itself so relative yaw starts at zero
    toff = tare_done ? AW'(tare_offset) : yw_q;

    priority if (cmd_q == q2e_pkg::CMD_SAMPLE) begin
      held_roll_next        = rr[14:0];
      held_pitch_next       = pp[13:0];
      held_heading_next     = hd[14:0];
      tare_offset_next      = toff[14:0];
      tare_done_next        = 1'b1;
      held_yaw_next         = 15'(q2e_pkg::wrap_half(yw_q - toff));
      held_accuracy_next    = acc_q;
      last_sample_time_next = now_q;
      seen_eff              = 1'b1;
    end else if (cmd_q == q2e_pkg::CMD_TARE) begin
      tare_offset_next = 15'(q2e_pkg::wrap_half(AW'(tare_offset) + AW'(held_yaw)));
      held_yaw_next    = '0;
    end else begin
      // Poll and the unused code report the held values only
    end

    age         = now_q - last_sample_time_next;
    healthy_now = seen_eff && (age <= 32'(fresh_timeout_ms));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tare_offset      <= '0;
      tare_done        <= 1'b0;
      last_sample_time <= '0;
      sample_seen      <= 1'b0;
      held_roll        <= '0;
      held_pitch       <= '0;
      held_heading     <= '0;
      held_yaw         <= '0;
      held_accuracy    <= '0;
    end else if (fin_go) begin
      tare_offset      <= tare_offset_next;
      tare_done        <= tare_done_next;
      last_sample_time <= last_sample_time_next;
      // Drop freshness once stale; only a new sample restores it
      sample_seen      <= healthy_now;
      held_roll        <= held_roll_next;
      held_pitch       <= held_pitch_next;
      held_heading     <= held_heading_next;
      held_yaw         <= held_yaw_next;
      held_accuracy    <= held_accuracy_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Response register: holds one finished result until its transfer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (fin_go) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      rsp.roll     <= held_roll_next;
      rsp.pitch    <= held_pitch_next;
      rsp.heading  <= held_heading_next;
      rsp.rel_yaw  <= held_yaw_next;
      rsp.accuracy <= held_accuracy_next;
      rsp.healthy  <= healthy_now;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mcnt  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          mcnt <= '0;
          if (req_xfer) begin
            state <= (req.cmd == q2e_pkg::CMD_SAMPLE) ? S_MUL : S_FINAL;
          end
        end
        S_MUL: begin
          mcnt <= mcnt + 4'd1;
          if (mcnt == M_END) state <= S_SQRT;
        end
        S_SQRT:  if (sq_done) state <= S_ROLL;
        S_ROLL:  if (cd_done) state <= S_PITCH;
        S_PITCH: if (cd_done) state <= S_YAW;
        S_YAW:   if (cd_done) state <= S_FINAL;
        S_FINAL: if (fin_go)  state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_cordic_done_in_run: assert property (@(posedge clk) disable iff (rst)
    cd_done |-> (state == S_ROLL || state == S_PITCH || state == S_YAW))
    else $error("CORDIC finished outside an angle run");

  a_sqrt_done_in_run: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> (state == S_SQRT))
    else $error("square root finished outside its run");

  a_sample_healthy: assert property (@(posedge clk) disable iff (rst)
    (fin_go && cmd_q == q2e_pkg::CMD_SAMPLE) |=> (rsp.valid && rsp.healthy))
    else $error("sample response not healthy");

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    fin_go |=> (rsp.heading < 15'd23040))
    else $error("heading out of range");

endmodule

`default_nettype wire
